FILE: rtl/core/v3n_pkg.sv
// Shared types, widths and constants for the 3D vector normalizer.
package v3n_pkg;

  localparam int CompW  = 32;
  localparam int SumW   = 64;
  localparam int MagW   = 32;
  localparam int QuotW  = 62;
  localparam int FracSh = 30;
  localparam int FifoDepthDef = 4;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    logic [SumW-1:0]  sum;
    logic [CompW:0]   abs_x;
    logic [CompW:0]   abs_y;
    logic [CompW:0]   abs_z;
    logic             neg_x;
    logic             neg_y;
    logic             neg_z;
    logic             zero;
  } v3n_item_t;

  typedef struct packed {
    logic [CompW-1:0] unit_x;
    logic [CompW-1:0] unit_y;
    logic [CompW-1:0] unit_z;
    logic [MagW-1:0]  magnitude;
    logic             zero_length;
  } v3n_res_t;

endpackage

FILE: rtl/core/v3n_front.sv
// Front part: magnitudes, signs, squares and their sum, two stages.
module v3n_front import v3n_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CompW-1:0] cx,
  input  logic [CompW-1:0] cy,
  input  logic [CompW-1:0] cz,
  output logic             out_valid,
  input  logic             out_ready,
  output v3n_item_t        out_item
);

  logic            s1_valid;
  logic [CompW:0]  s1_ax, s1_ay, s1_az;
  logic            s1_nx, s1_ny, s1_nz;
  logic [SumW-1:0] s1_sqx, s1_sqy, s1_sqz;
  logic [CompW:0]  ax, ay, az;
  logic [SumW-1:0] sqx, sqy, sqz;
  logic            s1_adv, s2_adv;

  assign ax = cx[CompW-1] ? ({1'b0, ~cx} + {{CompW{1'b0}}, 1'b1}) : {1'b0, cx};
  assign ay = cy[CompW-1] ? ({1'b0, ~cy} + {{CompW{1'b0}}, 1'b1}) : {1'b0, cy};
  assign az = cz[CompW-1] ? ({1'b0, ~cz} + {{CompW{1'b0}}, 1'b1}) : {1'b0, cz};

  // |comp| <= 2^31 fits in the low CompW bits; 32x32 unsigned products.
  assign sqx = ax[CompW-1:0] * ax[CompW-1:0];
  assign sqy = ay[CompW-1:0] * ay[CompW-1:0];
  assign sqz = az[CompW-1:0] * az[CompW-1:0];

  assign s2_adv   = !out_valid || out_ready;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_ready = s1_adv;

  // Stage 1: absolute values and the three squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
    if (s1_adv) begin
      s1_ax  <= ax;
      s1_ay  <= ay;
      s1_az  <= az;
      s1_nx  <= cx[CompW-1];
      s1_ny  <= cy[CompW-1];
      s1_nz  <= cz[CompW-1];
      s1_sqx <= sqx;
      s1_sqy <= sqy;
      s1_sqz <= sqz;
    end
  end

  // Stage 2: sum of squares and zero check.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s1_valid;
    end
    if (s2_adv) begin
      out_item.sum   <= s1_sqx + s1_sqy + s1_sqz;
      out_item.abs_x <= s1_ax;
      out_item.abs_y <= s1_ay;
      out_item.abs_z <= s1_az;
      out_item.neg_x <= s1_nx;
      out_item.neg_y <= s1_ny;
      out_item.neg_z <= s1_nz;
      out_item.zero  <= (s1_ax == '0) && (s1_ay == '0) && (s1_az == '0);
    end
  end

endmodule

FILE: rtl/core/v3n_fifo.sv
// Short queue between the front and back parts.
module v3n_fifo import v3n_pkg::*; #(
  parameter int Depth = FifoDepthDef
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  v3n_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output v3n_item_t rd_item
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  v3n_item_t         mem [Depth];
  logic [AW-1:0]     wptr, rptr;
  logic [AW:0]       count;
  logic              wr_fire, rd_fire;

  assign wr_ready = (count != (AW+1)'(Depth));
  assign rd_valid = (count != '0);
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;
  assign rd_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_fire) wptr <= (wptr == AW'(Depth-1)) ? '0 : wptr + 1'b1;
      if (rd_fire) rptr <= (rptr == AW'(Depth-1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(wr_fire) - (AW+1)'(rd_fire);
    end
    if (wr_fire) mem[wptr] <= wr_item;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(Depth)) else $error("fifo count overflow");
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    rd_valid == (count != '0)) else $error("fifo valid mismatch");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (wr_fire && !rd_fire) |=> count == $past(count) + 1'b1)
    else $error("fifo count step");
`endif

endmodule

FILE: rtl/core/v3n_back.sv
// Back part: pipelined square root, then pipelined restoring division.
module v3n_back import v3n_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  v3n_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output v3n_res_t  out_res
);

  localparam int SqSt = MagW;   // one root bit per stage
  localparam int DvSt = QuotW;  // one quotient bit per stage
  localparam int RemW = MagW + 2;
  localparam int DRW  = MagW + 1;
  localparam int NumW = CompW + 1 + FracSh;

  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // Square root pipeline state.
  logic             sv [SqSt+1];
  logic [SumW-1:0]  srad [SqSt+1];
  logic [RemW-1:0]  srem [SqSt+1];
  logic [MagW-1:0]  sroot [SqSt+1];
  v3n_item_t        sit [SqSt+1];

  always_comb begin
    sv[0]    = in_valid;
    srad[0]  = in_item.sum;
    srem[0]  = '0;
    sroot[0] = '0;
    sit[0]   = in_item;
  end

  for (genvar i = 0; i < SqSt; i++) begin : g_sqrt
    logic [RemW-1:0] r2, trial;
    logic            ok;
    always_comb begin
      r2    = {srem[i][RemW-3:0], srad[i][SumW-1:SumW-2]};
      trial = {sroot[i], 2'b01};
      ok    = (r2 >= trial);
    end
    always_ff @(posedge clk) begin
      if (rst) sv[i+1] <= 1'b0;
      else if (adv) sv[i+1] <= sv[i];
      if (adv) begin
        srad[i+1]  <= {srad[i][SumW-3:0], 2'b00};
        srem[i+1]  <= ok ? (r2 - trial) : r2;
        sroot[i+1] <= {sroot[i][MagW-2:0], ok};
        sit[i+1]   <= sit[i];
      end
    end
  end

  // Division pipeline: three lanes share the divisor.
  logic             dv   [DvSt+1];
  logic [MagW-1:0]  dmag [DvSt+1];
  logic [NumW-1:0]  dnum [3][DvSt+1];
  logic [DRW-1:0]   drem [3][DvSt+1];
  logic [QuotW-1:0] dq   [3][DvSt+1];
  logic [2:0]       dneg [DvSt+1];
  logic             dz   [DvSt+1];

  always_comb begin
    dv[0]      = sv[SqSt];
    dmag[0]    = sroot[SqSt];
    dnum[0][0] = NumW'({sit[SqSt].abs_x, {FracSh{1'b0}}});
    dnum[1][0] = NumW'({sit[SqSt].abs_y, {FracSh{1'b0}}});
    dnum[2][0] = NumW'({sit[SqSt].abs_z, {FracSh{1'b0}}});
    drem[0][0] = '0;
    drem[1][0] = '0;
    drem[2][0] = '0;
    dq[0][0]   = '0;
    dq[1][0]   = '0;
    dq[2][0]   = '0;
    dneg[0] = {sit[SqSt].neg_z, sit[SqSt].neg_y, sit[SqSt].neg_x};
    dz[0]   = sit[SqSt].zero;
  end

  // Numerator is below 2^QuotW; top NumW-QuotW bits are zero.
  for (genvar i = 0; i < DvSt; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv[i+1] <= 1'b0;
      else if (adv) dv[i+1] <= dv[i];
      if (adv) begin
        dmag[i+1] <= dmag[i];
        dneg[i+1] <= dneg[i];
        dz[i+1]   <= dz[i];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DRW:0] t;
      logic         ok;
      always_comb begin
        t  = {drem[l][i], dnum[l][i][QuotW-1]};
        ok = (t >= {1'b0, 1'b0, dmag[i]});
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dnum[l][i+1] <= {dnum[l][i][NumW-2:0], 1'b0};
          drem[l][i+1] <= ok ? DRW'(t - {2'b00, dmag[i]}) : DRW'(t);
          dq[l][i+1]   <= {dq[l][i][QuotW-2:0], ok};
        end
      end
    end
  end

  logic [CompW-1:0] ux [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ux[l] = dneg[DvSt][l] ? (CompW'(0) - dq[l][DvSt][CompW-1:0])
                            : dq[l][DvSt][CompW-1:0];
      if (dz[DvSt]) ux[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv[DvSt];
    if (adv) begin
      out_res.unit_x      <= ux[0];
      out_res.unit_y      <= ux[1];
      out_res.unit_z      <= ux[2];
      out_res.magnitude   <= dmag[DvSt];
      out_res.zero_length <= dz[DvSt];
    end
  end

`ifndef NO_ASSERTIONS
  a_zero_mag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.zero_length) |-> out_res.magnitude == '0)
    else $error("zero vector with nonzero magnitude");
  a_zero_unit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.zero_length) |-> (out_res.unit_x == '0 &&
      out_res.unit_y == '0 && out_res.unit_z == '0))
    else $error("zero vector with nonzero unit");
  a_nz_mag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.zero_length) |-> out_res.magnitude != '0)
    else $error("nonzero vector with zero magnitude");
`endif

endmodule

FILE: rtl/core/vec3_normalize_top.sv
// Top level of the 3D vector normalizer.
// Takes a signed Q15.16 vector per transfer and returns its floor-sqrt
// length (unsigned Q16.16) and unit vector (signed Q1.30, truncated toward
// zero); the zero vector gives zeros with zero_length set. One vector is
// accepted every cycle while the output side keeps taking results. A vector
// passes 2 front stages, the queue, 32 square-root stages (one root bit
// each) and 62 division stages (one quotient bit each, three lanes), then
// the output register. The queue lets the front keep taking transfers
// briefly while the back pipeline is held by the output side.
module vec3_normalize_top import v3n_pkg::*; #(
  parameter int FifoDepth = FifoDepthDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // comp_x[31:0], comp_y[63:32], comp_z[95:64]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // unit_x, unit_y, unit_z, magnitude
  output logic         m_tuser    // zero_length
);

  logic      f_valid, f_ready, q_valid, q_ready;
  v3n_item_t f_item, q_item;
  v3n_res_t  res;

  v3n_front u_front (
    .clk, .rst,
    .in_valid (s_tvalid), .in_ready (s_tready),
    .cx (s_tdata[31:0]), .cy (s_tdata[63:32]), .cz (s_tdata[95:64]),
    .out_valid (f_valid), .out_ready (f_ready), .out_item (f_item)
  );

  v3n_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk, .rst,
    .wr_valid (f_valid), .wr_ready (f_ready), .wr_item (f_item),
    .rd_valid (q_valid), .rd_ready (q_ready), .rd_item (q_item)
  );

  v3n_back u_back (
    .clk, .rst,
    .in_valid (q_valid), .in_ready (q_ready), .in_item (q_item),
    .out_valid (m_tvalid), .out_ready (m_tready), .out_res (res)
  );

  assign m_tdata = {res.magnitude, res.unit_z, res.unit_y, res.unit_x};
  assign m_tuser = res.zero_length;

endmodule
